// ===== design/dalc_pkg.sv =====
// ----------------------------------------------------------------------------
// dalc_pkg
// shared types, codes and constants of the door access lock controller
// ----------------------------------------------------------------------------
`default_nettype none

package dalc_pkg;

  // elapsed millisecond counter width (20 to 64)
  localparam int ELAPSED_BITS   = 32;
  localparam int MS_PER_SECOND  = 1000;
  localparam int SECONDS_BITS   = 16;
  localparam int DELAY_BITS     = 16;
  // 65535 s * 1000 fits in 26 bits
  localparam int LIMIT_BITS     = 26;
  localparam int CMP_BITS       = (ELAPSED_BITS > LIMIT_BITS) ? ELAPSED_BITS : LIMIT_BITS;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [DELAY_BITS-1:0] TAMPER_DELAY_RESET = 16'd10000;

  typedef enum logic [2:0] {
    MODE_SECURE     = 3'd0,
    MODE_UNLOCKED   = 3'd1,
    MODE_LOCKING    = 3'd2,
    MODE_OPEN       = 3'd3,
    MODE_ALARM      = 3'd4,
    MODE_UNALARMING = 3'd5,
    MODE_TAMPER     = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    RC_NONE        = 3'd0,
    RC_ACTIVATE    = 3'd1,
    RC_HOLD        = 3'd2,
    RC_RELEASE     = 3'd3,
    RC_RELEASE_OFF = 3'd4
  } relay_cmd_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RAISED  = 2'd1,
    EV_CLEARED = 2'd2
  } event_t;

  typedef enum logic {
    CMD_TICK     = 1'b0,
    CMD_ACTIVATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    USTAT_INACTIVE   = 2'd0,
    USTAT_ACTIVE     = 2'd1,
    USTAT_TRANSITION = 2'd2
  } unlock_status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_OPEN_SECONDS = 3'd0,
    REG_TAMPER_DELAY_MS  = 3'd1,
    REG_HAS_INDICATOR    = 3'd2,
    REG_HAS_ALARM_RELAY  = 3'd3,
    REG_HAS_OPEN_RELAY   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       cmd;
    logic       door_open;
    logic [1:0] unlock_status;
    logic       indicator_active;
    logic       indicator_normal;
    logic       alarm_active;
    logic       opener_inactive;
  } item_t;

  typedef struct packed {
    logic [2:0] door_state;
    logic       acted;
    logic [2:0] unlock_cmd;
    logic [2:0] indicator_cmd;
    logic [2:0] alarm_cmd;
    logic       opener_cmd;
    logic [1:0] tamper_event;
    logic [1:0] alarm_event;
  } result_t;

  // settings as seen by the sequencer
  typedef struct packed {
    logic [LIMIT_BITS-1:0] open_limit_ms;
    logic [DELAY_BITS-1:0] tamper_delay_ms;
    logic                  has_indicator;
    logic                  has_alarm_relay;
    logic                  has_open_relay;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/dalc_cfg.sv =====
// ----------------------------------------------------------------------------
// dalc_cfg
// configuration registers; the open limit is kept in milliseconds
// ----------------------------------------------------------------------------
`default_nettype none

module dalc_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [dalc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [dalc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output dalc_pkg::cfg_t                           cfg
);
  import dalc_pkg::*;

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_OPEN_SECONDS: begin
          // seconds to ms once, at write time
          cfg_next.open_limit_ms = LIMIT_BITS'(cfg_data[SECONDS_BITS-1:0])
                                   * LIMIT_BITS'(MS_PER_SECOND);
        end
        REG_TAMPER_DELAY_MS: cfg_next.tamper_delay_ms = cfg_data[DELAY_BITS-1:0];
        REG_HAS_INDICATOR:   cfg_next.has_indicator   = cfg_data[0];
        REG_HAS_ALARM_RELAY: cfg_next.has_alarm_relay = cfg_data[0];
        REG_HAS_OPEN_RELAY:  cfg_next.has_open_relay  = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_limit_ms   <= '0;
      cfg.tamper_delay_ms <= TAMPER_DELAY_RESET;
      cfg.has_indicator   <= 1'b1;
      cfg.has_alarm_relay <= 1'b1;
      cfg.has_open_relay  <= 1'b1;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/dalc_core.sv =====
// ----------------------------------------------------------------------------
// dalc_core
// lock sequencer state (mode, elapsed ms, open trigger) and its step logic
// ----------------------------------------------------------------------------
`default_nettype none

module dalc_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  dalc_pkg::item_t     item,
  input  dalc_pkg::cfg_t      cfg,
  output dalc_pkg::result_t   result
);
  import dalc_pkg::*;

  mode_t                   mode, mode_next;
  logic [ELAPSED_BITS-1:0] elapsed_ms, elapsed_ms_next, elapsed_inc;
  logic                    open_trigger, open_trigger_next;
  logic [CMP_BITS-1:0]     elapsed_cmp;
  logic                    open_timeout, tamper_timeout;
  logic                    ind;

  // saturating increment at the start of a tick
  assign elapsed_inc    = (&elapsed_ms) ? elapsed_ms : elapsed_ms + 1'b1;
  assign elapsed_cmp    = CMP_BITS'(elapsed_inc);
  assign open_timeout   = (cfg.open_limit_ms != '0)
                          && (elapsed_cmp > CMP_BITS'(cfg.open_limit_ms));
  assign tamper_timeout = elapsed_cmp > CMP_BITS'(cfg.tamper_delay_ms);
  assign ind            = cfg.has_indicator;

  always_comb begin
    mode_next         = mode;
    elapsed_ms_next   = elapsed_ms;
    open_trigger_next = open_trigger;
    result            = '0;

    if (item.cmd == CMD_ACTIVATE) begin
      mode_next            = MODE_UNLOCKED;
      elapsed_ms_next      = '0;
      result.unlock_cmd    = RC_ACTIVATE;
      if (ind) result.indicator_cmd = RC_ACTIVATE;
    end else begin
      elapsed_ms_next = elapsed_inc;
      unique case (mode)
        MODE_SECURE: begin
          if (cfg.has_alarm_relay && item.alarm_active) result.alarm_cmd = RC_RELEASE_OFF;
          if (ind && item.indicator_active) result.indicator_cmd = RC_RELEASE_OFF;
          open_trigger_next = 1'b1;
          if (item.door_open) begin
            elapsed_ms_next     = '0;
            open_trigger_next   = 1'b0;
            mode_next           = MODE_TAMPER;
            result.tamper_event = EV_RAISED;
          end
        end
        MODE_UNLOCKED: begin
          if (item.door_open) begin
            elapsed_ms_next   = '0;
            result.unlock_cmd = RC_HOLD;
            if (ind) result.indicator_cmd = RC_HOLD;
            mode_next         = MODE_OPEN;
          end else if (open_trigger && item.unlock_status == USTAT_ACTIVE) begin
            open_trigger_next = 1'b0;
            if (cfg.has_open_relay && item.opener_inactive) result.opener_cmd = 1'b1;
          end else if (item.unlock_status == USTAT_INACTIVE) begin
            if (ind) result.indicator_cmd = RC_RELEASE;
            elapsed_ms_next = '0;
            mode_next       = MODE_LOCKING;
          end
        end
        MODE_LOCKING: begin
          if (item.door_open) begin
            result.unlock_cmd = RC_HOLD;
            if (ind) result.indicator_cmd = RC_HOLD;
            mode_next    = MODE_OPEN;
            result.acted = 1'b1;
          end else if (item.unlock_status == USTAT_INACTIVE) begin
            mode_next = MODE_SECURE;
          end
        end
        MODE_OPEN: begin
          if (!item.door_open) begin
            result.unlock_cmd = RC_RELEASE;
            mode_next         = MODE_LOCKING;
            result.acted      = 1'b1;
          end else if (open_timeout) begin
            if (cfg.has_alarm_relay) result.alarm_cmd = RC_ACTIVATE;
            mode_next    = MODE_ALARM;
            result.acted = 1'b1;
          end
        end
        MODE_ALARM: begin
          if (!item.door_open) begin
            result.unlock_cmd = RC_RELEASE_OFF;
            if (ind) result.indicator_cmd = RC_RELEASE_OFF;
            mode_next    = MODE_UNALARMING;
            result.acted = 1'b1;
          end
        end
        MODE_UNALARMING: begin
          if (item.door_open) begin
            result.unlock_cmd = RC_HOLD;
            if (ind && item.indicator_normal) result.indicator_cmd = RC_HOLD;
            mode_next = MODE_ALARM;
          end else begin
            mode_next          = MODE_SECURE;
            result.alarm_event = EV_CLEARED;
          end
          result.acted = 1'b1;
        end
        MODE_TAMPER: begin
          if (!item.door_open) begin
            mode_next           = MODE_SECURE;
            result.acted        = 1'b1;
            result.tamper_event = EV_CLEARED;
          end else if (tamper_timeout) begin
            result.unlock_cmd = RC_HOLD;
            if (ind && item.indicator_normal) result.indicator_cmd = RC_HOLD;
            mode_next          = MODE_ALARM;
            result.acted       = 1'b1;
            result.alarm_event = EV_RAISED;
          end
        end
        default: begin
          // unused mode code falls into alarm
          elapsed_ms_next    = '0;
          mode_next          = MODE_ALARM;
          result.alarm_event = EV_RAISED;
        end
      endcase
    end

    result.door_state = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_LOCKING;
      elapsed_ms   <= '0;
      open_trigger <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      elapsed_ms   <= elapsed_ms_next;
      open_trigger <= open_trigger_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/door_access_lock_controller_unit.sv =====
// ----------------------------------------------------------------------------
// door_access_lock_controller_unit
// door lock sequencer: one tick or activate item in, one result item out
// ----------------------------------------------------------------------------
//
//  channel  | signals                               | handshake
//  ---------+---------------------------------------+----------------------
//  input    | in_valid, in_ready, in_item           | valid / ready
//  output   | out_valid, out_ready, out_item        | valid / ready
//  config   | cfg_write, cfg_index, cfg_data        | write enable, no wait
//
//  each item waits in the input register and then lands in the result
//  register, which drives out_valid; throughput is one item per cycle
//  while the output is not stalled; the sequencer state advances as the
//  item moves from the input register to the result register
//  a stalled output holds the result register and then the input register;
//  in_ready drops only when both are full and out_ready is low
//  rst is synchronous and puts the lock in locking with settings at default
//
`default_nettype none

module door_access_lock_controller_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // item input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  dalc_pkg::item_t                          in_item,
  // result output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output dalc_pkg::result_t                        out_item,
  // configuration
  input  wire logic                                cfg_write,
  input  wire logic [dalc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [dalc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import dalc_pkg::*;

  // input register stage
  logic    in_reg_valid;
  item_t   in_reg_item;
  logic    advance;      // input register moves into result register
  cfg_t    cfg;
  result_t step_result;

  // result register is free or being drained this cycle
  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_item <= in_item;
    end
  end

  dalc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state update and result for the item in the input register
  dalc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_reg_item),
    .cfg    (cfg),
    .result (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

endmodule

`default_nettype wire

// ===== design/dalc_checker.sv =====
// ----------------------------------------------------------------------------
// dalc_checker
// port level checks on the door access lock controller
// ----------------------------------------------------------------------------
`default_nettype none

module dalc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input dalc_pkg::result_t out_item
);
  import dalc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item valid after reset");

  // input only backs up behind a stalled result
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with the output free");

  // opener pulse only while staying unlocked
  a_opener_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.opener_cmd |-> out_item.door_state == MODE_UNLOCKED)
    else $error("opener pulse outside unlocked");

  // raised events land in their own mode
  a_event_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.tamper_event != EV_RAISED
                   || out_item.door_state == MODE_TAMPER)
               && (out_item.alarm_event != EV_RAISED
                   || out_item.door_state == MODE_ALARM))
    else $error("raised event with wrong mode");

endmodule

bind door_access_lock_controller_unit dalc_checker u_dalc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
